### rtl/kscd_pkg.sv
// Shared constants, types and helpers of the keyboard scancode decoder.
`timescale 1ns / 1ps
package kscd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  // Operation codes of an input item.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CMD    = 2'd2;

  // Event codes.
  localparam logic [1:0] EV_QUEUED   = 2'd0;
  localparam logic [1:0] EV_KBD_ERR  = 2'd1;
  localparam logic [1:0] EV_IGNORED  = 2'd2;
  localparam logic [1:0] EV_CONSUMED = 2'd3;

  // Set-1 scancodes and keyboard replies.
  localparam logic [7:0] SC_ERR_LOW     = 8'h00;
  localparam logic [7:0] SC_ERR_HIGH    = 8'hFF;
  localparam logic [7:0] SC_ACK         = 8'hFA;
  localparam logic [7:0] SC_ECHO        = 8'hEE;
  localparam logic [7:0] SC_BAT_FAIL    = 8'hFC;
  localparam logic [7:0] SC_RESEND      = 8'hFE;
  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
  localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
  localparam logic [7:0] SC_ALT_BRK     = 8'hB8;
  localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_CTRL_BRK    = 8'h9D;

  // Command sent to the keyboard to set its LEDs.
  localparam logic [7:0] CMD_SET_LEDS = 8'hED;

  // Bit positions in the modifier flags.
  localparam int FLAG_SHIFT = 0;
  localparam int FLAG_CAPS  = 1;
  localparam int FLAG_ALT   = 2;
  localparam int FLAG_ALTGR = 3;
  localparam int FLAG_CTRL  = 4;
  localparam int FLAG_W     = 5;

  typedef logic [FLAG_W-1:0] kscd_flags_t;

  // Outcome of decoding one scancode byte.
  typedef struct packed {
    logic        push;
    logic        prefix;
    kscd_flags_t flags;
    logic [1:0]  event_code;
    logic        caps_cmd;
  } kscd_dec_t;

  // LED byte: caps lock is bit 2, num and scroll lock stay off.
  function automatic logic [7:0] led_byte(input logic caps);
    return {5'b00000, caps, 2'b00};
  endfunction

endpackage

### rtl/kscd_if.sv
// Valid/ready channel interfaces for the decoder's input and result items.
`timescale 1ns / 1ps
interface kscd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] scan_byte;

  modport source (output valid, output operation, output scan_byte, input ready);
  modport sink   (input valid, input operation, input scan_byte, output ready);
endinterface

interface kscd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [1:0] event_code;
  logic       shift_down;
  logic       caps_on;
  logic       alt_down;
  logic       altgr_down;
  logic       ctrl_down;
  logic       last;

  modport source (output valid, output kind, output data_byte, output event_code,
                  output shift_down, output caps_on, output alt_down,
                  output altgr_down, output ctrl_down, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input event_code,
                  input shift_down, input caps_on, input alt_down,
                  input altgr_down, input ctrl_down, input last, output ready);
endinterface

### rtl/kscd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kscd_decode.sv
// Scancode classifier: prefix tracking, modifier updates and queue decision.
`timescale 1ns / 1ps
module kscd_decode
  import kscd_pkg::*;
(
  input  logic [7:0]  scan_byte,
  input  logic        prefix_in,
  input  kscd_flags_t flags_in,
  output kscd_dec_t   dec
);

  always_comb begin
    dec            = '0;
    dec.flags      = flags_in;
    dec.event_code = EV_QUEUED;
    if (prefix_in) begin
      // After 0xE0 only right alt and right ctrl are consumed; all else is queued.
      unique case (scan_byte)
        SC_ALT_MAKE: begin
          dec.flags[FLAG_ALTGR] = 1'b1;
          dec.event_code        = EV_CONSUMED;
        end
        SC_ALT_BRK: begin
          dec.flags[FLAG_ALTGR] = 1'b0;
          dec.event_code        = EV_CONSUMED;
        end
        SC_CTRL_MAKE: begin
          dec.flags[FLAG_CTRL] = 1'b1;
          dec.event_code       = EV_CONSUMED;
        end
        SC_CTRL_BRK: begin
          dec.flags[FLAG_CTRL] = 1'b0;
          dec.event_code       = EV_CONSUMED;
        end
        default: begin
          dec.push = 1'b1;
        end
      endcase
    end else begin
      unique case (scan_byte)
        SC_ERR_LOW, SC_ERR_HIGH: begin
          dec.event_code = EV_KBD_ERR;
        end
        SC_ACK, SC_ECHO, SC_BAT_FAIL, SC_RESEND: begin
          dec.event_code = EV_IGNORED;
        end
        SC_PREFIX: begin
          dec.prefix     = 1'b1;
          dec.event_code = EV_CONSUMED;
        end
        SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: begin
          dec.flags[FLAG_SHIFT] = 1'b1;
          dec.event_code        = EV_CONSUMED;
        end
        SC_LSHIFT_BRK, SC_RSHIFT_BRK: begin
          dec.flags[FLAG_SHIFT] = 1'b0;
          dec.event_code        = EV_CONSUMED;
        end
        SC_CAPS_MAKE: begin
          dec.flags[FLAG_CAPS] = ~flags_in[FLAG_CAPS];
          dec.event_code       = EV_CONSUMED;
          dec.caps_cmd         = 1'b1;
        end
        SC_ALT_MAKE: begin
          dec.flags[FLAG_ALT] = 1'b1;
          dec.event_code      = EV_CONSUMED;
        end
        SC_ALT_BRK: begin
          dec.flags[FLAG_ALT] = 1'b0;
          dec.event_code      = EV_CONSUMED;
        end
        SC_CTRL_MAKE: begin
          dec.flags[FLAG_CTRL] = 1'b1;
          dec.event_code       = EV_CONSUMED;
        end
        SC_CTRL_BRK: begin
          dec.flags[FLAG_CTRL] = 1'b0;
          dec.event_code       = EV_CONSUMED;
        end
        default: begin
          dec.push = 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/keyboard_scancode_decoder.sv
// Set-1 keyboard scancode decoder with a key byte queue held in RAM.
//
// Input channel in_if: each item is either a scancode byte from the keyboard
// (operation 0) or a request to read the oldest queued key byte (operation 1).
// Result channel out_if: one result per item, or two for a caps lock press
// (the LED command 0xED, then the LED byte); the field last marks the final one.
// Key bytes sit in a ring buffer in a synchronous RAM of QUEUE_DEPTH entries,
// which holds up to QUEUE_DEPTH-1 bytes and overwrites the oldest when full.
// Pointers, prefix and modifier flags update in the cycle an item is accepted;
// a read issues its RAM access then and the data returns in the next cycle.
// An accepted item waits in the stage register until the result register is
// free, and its first result is then registered onto out_if. Throughput:
// one item per cycle while the receiver keeps up; a caps lock press holds the
// result register for both of its results. A stage register and the result
// register separate the channels, so a new item is accepted while a finished
// result still waits. When the receiver stalls, results hold and in_if.ready
// drops once both registers are full.
// Reset (rst_n low at a clock edge) empties the queue and clears the prefix
// and all modifier states; the RAM contents are not cleared.
`timescale 1ns / 1ps
module keyboard_scancode_decoder
  import kscd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  kscd_in_if.sink           in_if,
  kscd_out_if.source        out_if
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Architectural state.
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             prefix_r, prefix_nxt;
  kscd_flags_t      flags_r, flags_nxt;

  // Stage register: accepted item, waiting for its RAM data or the result register.
  logic             s1_valid_r;
  logic [1:0]       s1_kind_r;
  logic [1:0]       s1_event_r;
  kscd_flags_t      s1_flags_r;
  logic             s1_empty_r;

  // Result register.
  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_data_r;
  logic [1:0]       out_event_r;
  kscd_flags_t      out_flags_r;
  logic             out_last_r;
  logic [7:0]       out_led_r;

  logic             in_fire;
  logic             out_fire;
  logic             s1_adv;
  logic             do_push;
  logic             do_pop;
  logic             q_empty;
  kscd_dec_t        dec;
  logic [7:0]       ram_rdata;
  logic [7:0]       s1_data;

  kscd_decode u_decode (
    .scan_byte (in_if.scan_byte),
    .prefix_in (prefix_r),
    .flags_in  (flags_r),
    .dec       (dec)
  );

  kscd_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (wr_ptr_r),
    .wdata (in_if.scan_byte),
    .re    (do_pop),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign out_fire    = out_valid_r & out_if.ready;
  // The stage moves on when the result register is empty or gives up its last beat.
  assign s1_adv      = s1_valid_r & (~out_valid_r | (out_fire & out_last_r));
  assign in_if.ready = ~s1_valid_r | s1_adv;
  assign in_fire     = in_if.valid & in_if.ready;

  assign q_empty = (wr_ptr_r == rd_ptr_r);
  assign do_push = in_fire & (in_if.operation == OP_SCAN) & dec.push;
  assign do_pop  = in_fire & (in_if.operation == OP_READ) & ~q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    prefix_nxt = prefix_r;
    flags_nxt  = flags_r;
    if (in_fire && in_if.operation == OP_SCAN) begin
      prefix_nxt = dec.prefix;
      flags_nxt  = dec.flags;
      if (dec.push) begin
        wr_ptr_nxt = next_ptr(wr_ptr_r);
        // A full queue drops its oldest byte.
        if (next_ptr(wr_ptr_r) == rd_ptr_r) begin
          rd_ptr_nxt = next_ptr(rd_ptr_r);
        end
      end
    end else if (do_pop) begin
      rd_ptr_nxt = next_ptr(rd_ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      prefix_r <= 1'b0;
      flags_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      prefix_r <= prefix_nxt;
      flags_r  <= flags_nxt;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_empty_r <= q_empty;
      if (in_if.operation == OP_READ) begin
        s1_kind_r  <= KIND_READ;
        s1_event_r <= EV_QUEUED;
        s1_flags_r <= flags_r;
      end else begin
        s1_kind_r  <= dec.caps_cmd ? KIND_CMD : KIND_STATUS;
        s1_event_r <= dec.event_code;
        s1_flags_r <= dec.flags;
      end
    end
  end

  // The RAM output holds while the stage waits, since it only reads on accept.
  always_comb begin
    unique case (s1_kind_r)
      KIND_READ:   s1_data = s1_empty_r ? 8'h00 : ram_rdata;
      KIND_CMD:    s1_data = CMD_SET_LEDS;
      default:     s1_data = 8'h00;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_fire && out_last_r) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r  <= s1_kind_r;
      out_data_r  <= s1_data;
      out_event_r <= s1_event_r;
      out_flags_r <= s1_flags_r;
      out_last_r  <= (s1_kind_r != KIND_CMD);
      out_led_r   <= led_byte(s1_flags_r[FLAG_CAPS]);
    end else if (out_fire && !out_last_r) begin
      // Second beat of the LED command.
      out_data_r <= out_led_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = out_kind_r;
  assign out_if.data_byte  = out_data_r;
  assign out_if.event_code = out_event_r;
  assign out_if.shift_down = out_flags_r[FLAG_SHIFT];
  assign out_if.caps_on    = out_flags_r[FLAG_CAPS];
  assign out_if.alt_down   = out_flags_r[FLAG_ALT];
  assign out_if.altgr_down = out_flags_r[FLAG_ALTGR];
  assign out_if.ctrl_down  = out_flags_r[FLAG_CTRL];
  assign out_if.last       = out_last_r;

endmodule
